// ===== src/voice_channel_steal_arbiter_core_macros.svh =====
// ---------------------------------------------------------------------------
// voice channel steal arbiter assertion macros
// shared property forms for the port-level checker
// ---------------------------------------------------------------------------
`ifndef VOICE_CHANNEL_STEAL_ARBITER_CORE_MACROS_SVH
`define VOICE_CHANNEL_STEAL_ARBITER_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define VCSA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define VCSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/vcsa_pkg.sv =====
// ---------------------------------------------------------------------------
// vcsa_pkg
// shared widths, codes and types of the voice channel steal arbiter
// ---------------------------------------------------------------------------
package vcsa_pkg;

   localparam int NUM_VOICES_DEF = 32;

   localparam int MODE_W = 2;
   localparam int ENT_W  = 11;
   localparam int SLOT_W = 9;
   localparam int LEN_W  = 20;
   localparam int TIME_W = 31;
   localparam int END_W  = 32;
   localparam int REL_W  = 5;
   localparam int IDX_OUT_W = 5;

   localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

   localparam logic [SLOT_W-1:0] SLOT_KEEP = 9'd256;
   localparam logic signed [END_W-1:0] LIFE_MAX = 32'sh7fff_ffff;
   localparam logic signed [ENT_W-1:0] LISTENER_RESET = -11'sd1;

   typedef struct packed {
      logic signed [ENT_W-1:0] owner;
      logic [SLOT_W-1:0]       slot;
      logic                    busy;
      logic [END_W-1:0]        end_time;
   } voice_entry_type;

   localparam int ENTRY_W = $bits(voice_entry_type);

   // controller to datapath
   typedef struct packed {
      logic take;
      logic scan_step;
      logic commit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic accept;
      logic req_start;
      logic scan_done;
      logic out_free;
   } dp_status_type;

   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

// ===== src/vcsa_req_if.sv =====
// ---------------------------------------------------------------------------
// vcsa_req_if
// request channel: start, release and clear-all transactions
// ---------------------------------------------------------------------------
interface vcsa_req_if;
   import vcsa_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [ENT_W-1:0]  owner_entity;
   logic [SLOT_W-1:0]        owner_slot;
   logic [LEN_W-1:0]         sound_length;
   logic [TIME_W-1:0]        now_time;
   logic [REL_W-1:0]         release_index;

   modport source (output valid, mode, owner_entity, owner_slot, sound_length,
                   now_time, release_index, input ready);
   modport sink (input valid, mode, owner_entity, owner_slot, sound_length,
                 now_time, release_index, output ready);
endinterface

// ===== src/vcsa_rsp_if.sv =====
// ---------------------------------------------------------------------------
// vcsa_rsp_if
// response channel: grant result of each request transaction
// ---------------------------------------------------------------------------
interface vcsa_rsp_if;
   import vcsa_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 granted;
   logic [IDX_OUT_W-1:0] voice_index;
   logic                 stole_busy;

   modport source (output valid, granted, voice_index, stole_busy, input ready);
   modport sink (input valid, granted, voice_index, stole_busy, output ready);
endinterface

// ===== src/vcsa_csr_if.sv =====
// ---------------------------------------------------------------------------
// vcsa_csr_if
// configuration write channel for the listener entity register
// ---------------------------------------------------------------------------
interface vcsa_csr_if;
   import vcsa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ENT_W-1:0] listener_entity;

   modport source (output valid, listener_entity, input ready);
   modport sink (input valid, listener_entity, output ready);
endinterface

// ===== src/vcsa_ram.sv =====
// ---------------------------------------------------------------------------
// vcsa_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module vcsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/vcsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// vcsa_ctrl
// sequencer: take a transaction, scan the voice table for a start, commit the result
// ---------------------------------------------------------------------------
module vcsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  vcsa_pkg::dp_status_type status,
   output vcsa_pkg::dp_cmd_type    cmd
);
   import vcsa_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.accept) begin
               state_in = status.req_start ? ST_SCAN : ST_COMMIT;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== src/vcsa_datapath.sv =====
// ---------------------------------------------------------------------------
// vcsa_datapath
// voice table, scan evaluation, table update and response register
// ---------------------------------------------------------------------------
module vcsa_datapath #(
   parameter int NUM_VOICES = vcsa_pkg::NUM_VOICES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   vcsa_req_if.sink                req,
   vcsa_rsp_if.source              rsp,
   vcsa_csr_if.sink                csr,
   input  vcsa_pkg::dp_cmd_type    cmd,
   output vcsa_pkg::dp_status_type status
);
   import vcsa_pkg::*;

   localparam int IDX_W = idx_width(NUM_VOICES);
   localparam int CNT_W = $clog2(NUM_VOICES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

   logic accept;

   // captured transaction
   logic [MODE_W-1:0]       mode_ff;
   logic signed [ENT_W-1:0] ent_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [TIME_W-1:0]       now_ff;
   logic [REL_W-1:0]        rel_ff;

   // scan state
   logic [CNT_W-1:0]        iss_cnt_ff, iss_cnt_in;
   logic                    ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]        ev_idx_ff, ev_idx_in;
   logic signed [END_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]        pick_ff, pick_in;
   logic                    pick_busy_ff, pick_busy_in;
   logic                    found_ff, found_in;
   logic                    refused_ff, refused_in;

   logic [NUM_VOICES-1:0]   vld_ff, vld_in;
   logic signed [ENT_W-1:0] listener_ff, listener_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    granted_ff, granted_in;
   logic [IDX_OUT_W-1:0]    vidx_ff, vidx_in;
   logic                    stole_ff, stole_in;

   logic                    rd_en;
   logic [ENTRY_W-1:0]      ram_rdata;
   logic                    wr_en;
   voice_entry_type         wr_entry;
   voice_entry_type         entry_q;
   logic                    is_match;
   logic                    skip;
   logic signed [END_W-1:0] life;
   logic                    grant;

   // no handshake is offered while reset is held
   assign accept = req.valid && cmd.take && !reset;
   assign req.ready = cmd.take && !reset;
   assign csr.ready = !reset;

   assign rd_en = cmd.scan_step && (iss_cnt_ff < CNT_W'(NUM_VOICES));

   vcsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_VOICES),
      .ADDR_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pick_ff),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(IDX_W'(iss_cnt_ff)),
      .rd_data(ram_rdata)
   );

   // an entry that is not marked valid reads as a freed voice
   assign entry_q = vld_ff[ev_idx_ff] ? voice_entry_type'(ram_rdata) : '0;

   assign is_match = (entry_q.owner == ent_ff) && (entry_q.slot == slot_ff) &&
                     (slot_ff != '0);
   assign skip = (entry_q.owner == listener_ff) && (ent_ff != listener_ff) &&
                 entry_q.busy;
   assign life = $signed(entry_q.end_time - {1'b0, now_ff});

   assign grant = found_ff && !refused_ff;

   always_comb begin
      wr_entry.owner    = ent_ff;
      wr_entry.slot     = slot_ff;
      wr_entry.busy     = 1'b1;
      wr_entry.end_time = END_W'(now_ff) + END_W'(len_ff);
   end

   assign wr_en = cmd.commit && (mode_ff == MODE_START) && grant;

   always_comb begin
      iss_cnt_in   = iss_cnt_ff;
      ev_valid_in  = ev_valid_ff;
      ev_idx_in    = ev_idx_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      pick_busy_in = pick_busy_ff;
      found_in     = found_ff;
      refused_in   = refused_ff;
      if (accept) begin
         iss_cnt_in   = '0;
         ev_valid_in  = 1'b0;
         ev_idx_in    = '0;
         best_in      = LIFE_MAX;
         pick_in      = '0;
         pick_busy_in = 1'b0;
         found_in     = 1'b0;
         refused_in   = 1'b0;
      end else if (cmd.scan_step) begin
         ev_valid_in = rd_en;
         ev_idx_in   = IDX_W'(iss_cnt_ff);
         if (rd_en) begin
            iss_cnt_in = iss_cnt_ff + CNT_W'(1);
         end
         if (ev_valid_ff) begin
            priority if (is_match) begin
               if ((slot_ff == SLOT_KEEP) && entry_q.busy) begin
                  refused_in = 1'b1;
               end else begin
                  found_in     = 1'b1;
                  pick_in      = ev_idx_ff;
                  pick_busy_in = entry_q.busy;
               end
            end else if (!skip && (life < best_ff)) begin
               best_in      = life;
               pick_in      = ev_idx_ff;
               pick_busy_in = entry_q.busy;
               found_in     = 1'b1;
            end
         end
      end
   end

   always_comb begin
      status.accept    = accept;
      status.req_start = (req.mode == MODE_START);
      status.scan_done = ev_valid_ff && (is_match || (ev_idx_ff == LAST_IDX));
      status.out_free  = !rsp_valid_ff || rsp.ready;
   end

   always_comb begin
      vld_in       = vld_ff;
      listener_in  = listener_ff;
      rsp_valid_in = rsp_valid_ff;
      granted_in   = granted_ff;
      vidx_in      = vidx_ff;
      stole_in     = stole_ff;
      if (csr.valid) begin
         listener_in = csr.listener_entity;
      end
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         granted_in   = 1'b0;
         vidx_in      = '0;
         stole_in     = 1'b0;
         unique case (mode_ff)
            MODE_START: begin
               if (grant) begin
                  vld_in[pick_ff] = 1'b1;
                  granted_in      = 1'b1;
                  vidx_in         = IDX_OUT_W'(pick_ff);
                  stole_in        = pick_busy_ff;
               end
            end
            MODE_RELEASE: begin
               if (int'(rel_ff) < NUM_VOICES) begin
                  vld_in[IDX_W'(rel_ff)] = 1'b0;
               end
            end
            MODE_CLEAR: begin
               vld_in = '0;
            end
            default: begin
               vld_in = vld_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         listener_ff  <= LISTENER_RESET;
         rsp_valid_ff <= 1'b0;
         ev_valid_ff  <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         listener_ff  <= listener_in;
         rsp_valid_ff <= rsp_valid_in;
         ev_valid_ff  <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req.mode;
         ent_ff  <= req.owner_entity;
         slot_ff <= req.owner_slot;
         len_ff  <= req.sound_length;
         now_ff  <= req.now_time;
         rel_ff  <= req.release_index;
      end
      iss_cnt_ff   <= iss_cnt_in;
      ev_idx_ff    <= ev_idx_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      pick_busy_ff <= pick_busy_in;
      found_ff     <= found_in;
      refused_ff   <= refused_in;
      granted_ff   <= granted_in;
      vidx_ff      <= vidx_in;
      stole_ff     <= stole_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.granted     = granted_ff;
   assign rsp.voice_index = vidx_ff;
   assign rsp.stole_busy  = stole_ff;
endmodule

// ===== src/voice_channel_steal_arbiter_core.sv =====
// ---------------------------------------------------------------------------
// voice_channel_steal_arbiter_core
// voice allocation with stealing of the voice with the least remaining life
// ---------------------------------------------------------------------------
//  channel    direction  carries
//  req_chan   in         mode, owner entity/slot, length, time, release index
//  rsp_chan   out        granted, voice index, stole busy
//  csr_chan   in         listener entity register write
//
// a start transaction scans the table one voice per cycle through the ram
// read port, and stops at the first owner and slot match or at the last voice
// release, clear-all and unused modes skip the scan and go straight to commit
// synchronous reset frees every voice and sets the listener to -1 at once
// a stalled response is held in its register; the next request is taken
// meanwhile and waits only at its own commit step
// ---------------------------------------------------------------------------
module voice_channel_steal_arbiter_core #(
   parameter int NUM_VOICES = vcsa_pkg::NUM_VOICES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   vcsa_req_if.sink   req_chan,
   vcsa_rsp_if.source rsp_chan,
   vcsa_csr_if.sink   csr_chan
);
   import vcsa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   vcsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .status(status),
      .cmd   (cmd)
   );

   vcsa_datapath #(
      .NUM_VOICES(NUM_VOICES)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .csr   (csr_chan),
      .cmd   (cmd),
      .status(status)
   );
endmodule

// ===== src/vcsa_checker.sv =====
// ---------------------------------------------------------------------------
// vcsa_checker
// port-level checks of the arbiter, bound to the top level
// ---------------------------------------------------------------------------
`include "voice_channel_steal_arbiter_core_macros.svh"

module vcsa_checker #(
   parameter int NUM_VOICES = vcsa_pkg::NUM_VOICES_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_granted,
   input logic [4:0] rsp_voice_index,
   input logic       rsp_stole_busy
);
   // the sequencer leaves idle after each accepted transaction, so ready is low in the cycle after accept
   `VCSA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   // a refused or non-start transaction reports all zeros
   `VCSA_ASSERT_SAME(a_zero_when_refused, rsp_valid && !rsp_granted, (rsp_voice_index == 5'd0) && !rsp_stole_busy, "nonzero fields without grant")
   // a granted voice lies inside the table
   `VCSA_ASSERT_SAME(a_index_in_range, rsp_valid && rsp_granted, int'(rsp_voice_index) < NUM_VOICES, "voice index out of range")
   // stalled response holds
   `VCSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted) && $stable(rsp_voice_index) && $stable(rsp_stole_busy), "response changed under stall")
endmodule

bind voice_channel_steal_arbiter_core vcsa_checker #(
   .NUM_VOICES(NUM_VOICES)
) u_vcsa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_granted    (rsp_chan.granted),
   .rsp_voice_index(rsp_chan.voice_index),
   .rsp_stole_busy (rsp_chan.stole_busy)
);

// ===== test/tb_voice_channel_steal_arbiter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_voice_channel_steal_arbiter_core
// self-checking bench for the voice allocation arbiter: a queue-fed driver
// offers start, release, clear-all and unused-mode transactions, a voice
// table model predicts every grant, and a monitor compares each response
// in order; the listener register is rewritten between phases while idle
// ---------------------------------------------------------------------------
module tb_voice_channel_steal_arbiter_core;
   import vcsa_pkg::*;

   localparam int VOICES       = NUM_VOICES_DEF;
   localparam int PERIOD_NS    = 20;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_PCT     = 22;
   localparam int HOLD_CYCLES  = 400;
   localparam int TARGET_ITEMS = 700;
   localparam int DRAIN_CYCLES = 60;
   localparam longint TIMEOUT_NS = 64'd20_000_000;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [LEN_W-1:0]  LEN_MAX     = '1;
   localparam logic [TIME_W-1:0] TIME_MAX    = '1;
   localparam logic [TIME_W-1:0] TIME_NEAR_TOP = 31'h7ff0_0000;

   typedef struct {
      logic [MODE_W-1:0]       mode;
      logic signed [ENT_W-1:0] owner_entity;
      logic [SLOT_W-1:0]       owner_slot;
      logic [LEN_W-1:0]        sound_length;
      logic [TIME_W-1:0]       now_time;
      logic [REL_W-1:0]        release_index;
   } voice_request_type;

   typedef struct {
      logic                 granted;
      logic [IDX_OUT_W-1:0] voice_index;
      logic                 stole_busy;
   } voice_grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vcsa_req_if req_chan ();
   vcsa_rsp_if rsp_chan ();
   vcsa_csr_if csr_chan ();

   voice_channel_steal_arbiter_core #(
      .NUM_VOICES(VOICES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   always #(PERIOD_NS / 2) clock = ~clock;

   // voice table as the block should hold it
   logic signed [ENT_W-1:0] mix_owner [VOICES];
   logic [SLOT_W-1:0]       mix_slot [VOICES];
   logic                    mix_busy [VOICES];
   logic [END_W-1:0]        mix_end [VOICES];
   logic signed [ENT_W-1:0] listener_now;

   voice_request_type pending_reqs [$];
   voice_grant_type   grants_due [$];
   voice_request_type offered;

   int  error_count     = 0;
   int  queued_items    = 0;
   int  ignored_items   = 0;
   int  accepted_count  = 0;
   int  results_checked = 0;
   int  grants_seen     = 0;
   int  refusals_seen   = 0;
   int  busy_steals     = 0;
   int  settings_written = 0;
   int  hold_requests   = 0;
   int  hold_served     = 0;
   int  hold_left       = 0;
   bit  steady          = 1'b0;
   logic [TIME_W-1:0] paint_time = '0;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void free_voice(input int v);
      mix_owner[v] = '0;
      mix_slot[v]  = '0;
      mix_busy[v]  = 1'b0;
      mix_end[v]   = '0;
   endfunction

   function automatic void free_all_voices();
      int v;
      for (v = 0; v < VOICES; v++) free_voice(v);
   endfunction

   function automatic voice_grant_type arbitrate_voice(input voice_request_type r);
      voice_grant_type g;
      logic hit;
      logic refused;
      logic stop;
      int pick;
      int v;
      logic signed [END_W-1:0] best;
      logic signed [END_W-1:0] life;
      g.granted = 1'b0;
      g.voice_index = '0;
      g.stole_busy = 1'b0;
      hit = 1'b0;
      refused = 1'b0;
      stop = 1'b0;
      pick = 0;
      best = LIFE_MAX;
      case (r.mode)
         MODE_START: begin
            for (v = 0; v < VOICES && !stop; v++) begin
               if (mix_owner[v] == r.owner_entity && mix_slot[v] == r.owner_slot &&
                   r.owner_slot != '0) begin
                  // own sound in the same slot is replaced, unless it is a busy keep slot
                  if (r.owner_slot == SLOT_KEEP && mix_busy[v]) begin
                     refused = 1'b1;
                  end else begin
                     hit = 1'b1;
                     pick = v;
                  end
                  stop = 1'b1;
               end else if (!(mix_owner[v] == listener_now &&
                              r.owner_entity != listener_now && mix_busy[v])) begin
                  life = mix_end[v] - {1'b0, r.now_time};
                  if (life < best) begin
                     best = life;
                     pick = v;
                     hit = 1'b1;
                  end
               end
            end
            if (hit && !refused) begin
               g.granted = 1'b1;
               g.voice_index = IDX_OUT_W'(pick);
               g.stole_busy = mix_busy[pick];
               grants_seen++;
               if (mix_busy[pick]) busy_steals++;
               mix_owner[pick] = r.owner_entity;
               mix_slot[pick] = r.owner_slot;
               mix_busy[pick] = 1'b1;
               mix_end[pick] = {1'b0, r.now_time} + END_W'(r.sound_length);
            end else begin
               refusals_seen++;
            end
         end
         MODE_RELEASE: free_voice(int'(r.release_index));
         MODE_CLEAR: free_all_voices();
         default: ;
      endcase
      return g;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            grants_due.push_back(arbitrate_voice(offered));
            accepted_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               offered = pending_reqs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.mode <= offered.mode;
               req_chan.owner_entity <= offered.owner_entity;
               req_chan.owner_slot <= offered.owner_slot;
               req_chan.sound_length <= offered.sound_length;
               req_chan.now_time <= offered.now_time;
               req_chan.release_index <= offered.release_index;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // long response hold-off, counted here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end
   end

   task automatic check_grant();
      voice_grant_type want;
      if (grants_due.size() == 0) begin
         report_mismatch("response transaction with no request outstanding");
      end else begin
         want = grants_due.pop_front();
         if (rsp_chan.granted !== want.granted)
            report_mismatch($sformatf("result %0d granted: got %b expected %b",
               results_checked, rsp_chan.granted, want.granted));
         if (rsp_chan.voice_index !== want.voice_index)
            report_mismatch($sformatf("result %0d voice_index: got %0d expected %0d",
               results_checked, rsp_chan.voice_index, want.voice_index));
         if (rsp_chan.stole_busy !== want.stole_busy)
            report_mismatch($sformatf("result %0d stole_busy: got %b expected %b",
               results_checked, rsp_chan.stole_busy, want.stole_busy));
      end
      results_checked++;
   endtask

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_grant();
         rsp_chan.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic push_req(input voice_request_type r);
      pending_reqs.push_back(r);
      queued_items++;
      if (r.mode == MODE_UNUSED) ignored_items++;
   endtask

   task automatic push_start(input logic signed [ENT_W-1:0] ent, input logic [SLOT_W-1:0] slot,
                             input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] now);
      push_req('{mode: MODE_START, owner_entity: ent, owner_slot: slot, sound_length: len,
                 now_time: now, release_index: REL_W'($urandom)});
   endtask

   task automatic push_release(input logic [REL_W-1:0] idx);
      push_req('{mode: MODE_RELEASE, owner_entity: ENT_W'($urandom),
                 owner_slot: SLOT_W'($urandom), sound_length: LEN_W'($urandom),
                 now_time: TIME_W'($urandom), release_index: idx});
   endtask

   task automatic push_clear();
      push_req('{mode: MODE_CLEAR, owner_entity: ENT_W'($urandom),
                 owner_slot: SLOT_W'($urandom), sound_length: LEN_W'($urandom),
                 now_time: TIME_W'($urandom), release_index: REL_W'($urandom)});
   endtask

   task automatic push_unused();
      push_req('{mode: MODE_UNUSED, owner_entity: ENT_W'($urandom),
                 owner_slot: SLOT_W'($urandom), sound_length: LEN_W'($urandom),
                 now_time: TIME_W'($urandom), release_index: REL_W'($urandom)});
   endtask

   function automatic logic signed [ENT_W-1:0] any_entity();
      return ENT_W'(int'($urandom_range(1024)) - 1);
   endfunction

   // small pools so that owners and slots collide often
   function automatic logic signed [ENT_W-1:0] pick_entity();
      case ($urandom_range(9))
         0: return -11'sd1;
         1: return '0;
         2: return 11'sd1023;
         3, 4: return listener_now;
         5, 6, 7: return ENT_W'($urandom_range(3, 1));
         default: return any_entity();
      endcase
   endfunction

   function automatic logic signed [ENT_W-1:0] pick_other(input logic signed [ENT_W-1:0] not_this);
      logic signed [ENT_W-1:0] e;
      do e = pick_entity(); while (e == not_this);
      return e;
   endfunction

   function automatic logic signed [ENT_W-1:0] pick_listener();
      case ($urandom_range(4))
         0: return LISTENER_RESET;
         1: return '0;
         2: return 11'sd1023;
         3: return ENT_W'($urandom_range(3, 1));
         default: return any_entity();
      endcase
   endfunction

   function automatic logic [SLOT_W-1:0] pick_slot();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return SLOT_KEEP;
         4, 5, 6, 7: return SLOT_W'($urandom_range(3, 1));
         default: return SLOT_W'($urandom);
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(9))
         0: return '0;
         1: return LEN_MAX;
         2: return LEN_W'($urandom);
         default: return LEN_W'($urandom_range(5000, 1));
      endcase
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_chan.valid || grants_due.size() != 0);
   endtask

   task automatic write_listener(input logic signed [ENT_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.listener_entity <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      listener_now = value;
      settings_written++;
      @(negedge clock);
   endtask

   // the listener takes every voice, then others must be refused
   task automatic fill_for_listener();
      logic [TIME_W-1:0] t;
      int k;
      t = TIME_W'($urandom);
      push_clear();
      for (k = 1; k <= VOICES; k++)
         push_start(listener_now, SLOT_W'(k), LEN_W'($urandom_range(LEN_MAX, 1)), t);
      for (k = 0; k < 4; k++)
         push_start(pick_other(listener_now), pick_slot(), pick_length(), t + TIME_W'(k));
      push_start(listener_now, '0, pick_length(), t + TIME_W'(10));
      push_release(REL_W'($urandom));
      push_start(pick_other(listener_now), pick_slot(), pick_length(), t + TIME_W'(11));
      push_start(pick_other(listener_now), pick_slot(), pick_length(), t + TIME_W'(12));
   endtask

   // every voice left with exactly the largest life, which does not qualify
   task automatic saturate_lives();
      logic signed [ENT_W-1:0] filler;
      logic signed [ENT_W-1:0] asker;
      int k;
      filler = pick_other(listener_now);
      asker = pick_other(listener_now);
      push_clear();
      for (k = 1; k <= VOICES; k++)
         push_start(filler, SLOT_W'(k), LEN_MAX, TIME_NEAR_TOP);
      push_start(asker, '0, pick_length(), '0);
      push_start(asker, '0, pick_length(), TIME_W'(1));
      push_start(filler, SLOT_W'(2), LEN_MAX, TIME_MAX);
      push_start(asker, '0, pick_length(), '0);
   endtask

   task automatic mix_scene(input int n);
      int k;
      int r;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(19))
            0: paint_time = TIME_W'($urandom);
            1: paint_time = paint_time - TIME_W'($urandom_range(3000));
            default: paint_time = paint_time + TIME_W'($urandom_range(1500));
         endcase
         r = $urandom_range(99);
         if (r < 72) push_start(pick_entity(), pick_slot(), pick_length(), paint_time);
         else if (r < 87) push_release(REL_W'($urandom));
         else if (r < 90) push_clear();
         else push_unused();
      end
   endtask

   initial begin
      int scene_no;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_START;
      req_chan.owner_entity = '0;
      req_chan.owner_slot = '0;
      req_chan.sound_length = '0;
      req_chan.now_time = '0;
      req_chan.release_index = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.listener_entity = '0;
      free_all_voices();
      listener_now = LISTENER_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      write_listener(11'sd5);
      push_start(11'sd5, 9'd1, 20'd100, '0);
      push_start(11'sd5, 9'd1, 20'd50, 31'd10);          // same owner and slot reused
      push_start(11'sd7, SLOT_KEEP, LEN_MAX, 31'd20);
      push_start(11'sd7, SLOT_KEEP, 20'd5, 31'd30);       // busy keep slot refused
      push_start(-11'sd1, '0, '0, TIME_MAX);              // slot zero never matches
      push_start(-11'sd1, '0, '0, TIME_MAX);
      push_start(11'sd1023, '1, LEN_MAX, TIME_MAX);
      push_start(11'sd1023, '1, '0, '0);
      push_release('0);
      push_release('1);
      push_req('{mode: MODE_UNUSED, owner_entity: '1, owner_slot: '1, sound_length: '1,
                 now_time: '1, release_index: '1});
      push_req('{mode: MODE_UNUSED, owner_entity: '0, owner_slot: '0, sound_length: '0,
                 now_time: '0, release_index: '0});
      push_start(11'sd9, 9'd4, 20'd200, 31'd40);
      push_clear();
      push_start('0, '0, '0, '0);
      push_start('0, 9'd3, 20'd1, '0);
      push_start(11'sd5, 9'd1, 20'd1, 31'd5);
      push_start(11'sd9, 9'd1, 20'd1, 31'd5);
      push_release(5'd1);

      scene_no = 0;
      while (queued_items < TARGET_ITEMS) begin
         wait_idle();
         case (scene_no)
            0: begin
               write_listener(11'sd1023);
               fill_for_listener();
            end
            1: begin
               write_listener('0);
               saturate_lives();
            end
            2: begin
               write_listener(LISTENER_RESET);
               hold_requests++;
               mix_scene(60);
            end
            3: begin
               steady = 1'b1;
               mix_scene(80);
               wait_idle();
               steady = 1'b0;
            end
            default: begin
               if ($urandom_range(1)) write_listener(pick_listener());
               case ($urandom_range(7))
                  0: begin
                     write_listener(pick_listener());
                     fill_for_listener();
                  end
                  1: saturate_lives();
                  default: mix_scene($urandom_range(80, 30));
               endcase
            end
         endcase
         scene_no++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (grants_due.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", grants_due.size()));
      $display("Checked %0d responses for %0d requests (%0d ignored mode): %0d grants,",
               results_checked, accepted_count, ignored_items, grants_seen);
      $display("%0d refusals, %0d busy steals, %0d listener writes, one %0d-cycle stall",
               refusals_seen, busy_steals, settings_written, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout: %0d requests still queued, %0d responses outstanding",
               pending_reqs.size(), grants_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
